/* rtl/call_depth_tracker_macros.svh */
// Assertion macros shared by the call depth tracker RTL.
`ifndef CALL_DEPTH_TRACKER_MACROS_SVH
`define CALL_DEPTH_TRACKER_MACROS_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define CTD_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define CTD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/ctd_pkg.sv */
// Types and constants shared by the call depth tracker modules.
package ctd_pkg;

   localparam int ADDR_W      = 48;
   localparam int NEST_W      = 6;
   localparam int KIND_W      = 2;
   localparam int REQ_TDATA_W = 48;
   localparam int RSP_TDATA_W = 16;

   localparam logic [KIND_W-1:0] KIND_FIRST   = 2'd0;
   localparam logic [KIND_W-1:0] KIND_SAME    = 2'd1;
   localparam logic [KIND_W-1:0] KIND_DEEPER  = 2'd2;
   localparam logic [KIND_W-1:0] KIND_SHALLOW = 2'd3;

   typedef logic [ADDR_W-1:0] addr_type;

   typedef struct packed {
      logic grows;
      logic load;
      logic shift;
      logic clear;
   } cell_ctrl_type;

   typedef struct packed {
      logic equal;
      logic deeper;
      logic stop;
   } cell_stat_type;

endpackage

/* rtl/call_depth_tracker.sv */
// Call depth tracker top level: request control, chain of stack cells and result register.
//
// Each request carries the frame address of a newly entered function on
// req_tdata. The block answers every request with one response holding the
// estimated nesting level, the kind of move and an overflow flag.
// csr_wr_en with csr_wr_data sets the stack growth direction (1 when deeper
// frames have larger addresses); write it only while the block is idle.
// A first call, a call at the same level or a deeper call needs no search:
// the response is valid in the cycle after the request is accepted, and a
// new request can be taken every cycle while the output register can be freed.
// A shallower call sends a token down the cell chain, one cell per cycle,
// until it reaches the cell just above the deepest entry that is shallower
// than the new address, or cell zero. No new request is accepted until the
// search has stopped.
// The response sits in an output register, so the next request is accepted
// while it waits unless that register is still full and rsp_tready is low.
// When the receiver stalls, rsp_tvalid and rsp_tdata hold and req_tready
// drops once the register cannot be freed.
// Reset clears the level, the first-call flag, the direction and the token
// chain; the stored addresses need no clearing.
`include "call_depth_tracker_macros.svh"

module call_depth_tracker #(
   parameter int STACK_DEPTH = 64
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [ctd_pkg::REQ_TDATA_W-1:0] req_tdata,  // [47:0] frame_address
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [ctd_pkg::RSP_TDATA_W-1:0] rsp_tdata,  // [5:0] level, [7:6] move_kind,
                                                       // [8] overflow, [15:9] zero
   input  logic                            csr_wr_en,
   input  logic                            csr_wr_data
);
   import ctd_pkg::*;

   localparam int LVL_W = $clog2(STACK_DEPTH);
   localparam logic [LVL_W-1:0] LVL_TOP = LVL_W'(STACK_DEPTH - 1);

   logic             busy_ff, busy_in;
   logic [LVL_W-1:0] lvl_ff, lvl_in;
   logic             seen_ff, seen_in;
   logic             grows_ff;
   addr_type         addr_ff, addr_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [NEST_W-1:0] nest_ff, nest_in;
   logic [KIND_W-1:0] kind_ff, kind_in;
   logic             ovf_ff, ovf_in;

   logic             accept;
   logic             done;
   logic [LVL_W-1:0] new_level;
   addr_type         addr_bus;
   cell_ctrl_type    ctrl;
   logic             stop_any;

   cell_stat_type    stat [STACK_DEPTH];
   logic [STACK_DEPTH-1:0] equal_vec;
   logic [STACK_DEPTH-1:0] deeper_vec;
   logic [STACK_DEPTH-1:0] stop_vec;
   logic [STACK_DEPTH-1:0] tok_vec;
   logic [STACK_DEPTH-1:0] sel_vec;
   logic [STACK_DEPTH-1:0] wr_vec;

   assign req_tready = ~busy_ff & (~rsp_valid_ff | rsp_tready);
   assign accept     = req_tvalid & req_tready;
   assign addr_bus   = busy_ff ? addr_ff : req_tdata[ADDR_W-1:0];
   assign stop_any   = |stop_vec;

   for (genvar k = 0; k < STACK_DEPTH; k++) begin : g_cell
      logic from_above;
      logic below;

      if (k == STACK_DEPTH - 1) begin : g_top
         assign from_above = 1'b0;
      end else begin : g_mid
         assign from_above = tok_vec[k+1];
      end

      if (k == 0) begin : g_bottom
         assign below = 1'b1;
      end else begin : g_upper
         assign below = deeper_vec[k-1];
      end

      assign sel_vec[k] = (lvl_ff == LVL_W'(k));
      assign wr_vec[k]  = done & (new_level == LVL_W'(k));

      ctd_cell u_cell (
         .clock          (clock),
         .reset          (reset),
         .addr           (addr_bus),
         .ctrl           (ctrl),
         .sel            (sel_vec[k]),
         .wr_en          (wr_vec[k]),
         .tok_from_above (from_above),
         .below_deeper   (below),
         .stat           (stat[k]),
         .tok            (tok_vec[k])
      );

      assign equal_vec[k]  = stat[k].equal;
      assign deeper_vec[k] = stat[k].deeper;
      assign stop_vec[k]   = stat[k].stop;
   end

   always_comb begin
      busy_in      = busy_ff;
      lvl_in       = lvl_ff;
      seen_in      = seen_ff;
      addr_in      = addr_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      nest_in      = nest_ff;
      kind_in      = kind_ff;
      ovf_in       = ovf_ff;
      done         = 1'b0;
      new_level    = lvl_ff;
      ctrl.grows   = grows_ff;
      ctrl.load    = 1'b0;
      ctrl.shift   = 1'b0;
      ctrl.clear   = 1'b0;

      if (accept) begin
         if (!seen_ff) begin
            done      = 1'b1;
            new_level = '0;
            kind_in   = KIND_FIRST;
            ovf_in    = 1'b0;
         end else if (equal_vec[lvl_ff]) begin
            done    = 1'b1;
            kind_in = KIND_SAME;
            ovf_in  = 1'b0;
         end else if (deeper_vec[lvl_ff]) begin
            done    = 1'b1;
            kind_in = KIND_DEEPER;
            if (lvl_ff == LVL_TOP) begin
               ovf_in = 1'b1;
            end else begin
               new_level = lvl_ff + 1'b1;
               ovf_in    = 1'b0;
            end
         end else begin
            ctrl.load = 1'b1;
            busy_in   = 1'b1;
            addr_in   = req_tdata[ADDR_W-1:0];
         end
      end else if (busy_ff) begin
         if (stop_any) begin
            done       = 1'b1;
            kind_in    = KIND_SHALLOW;
            ovf_in     = 1'b0;
            ctrl.clear = 1'b1;
            busy_in    = 1'b0;
         end else begin
            ctrl.shift = 1'b1;
            lvl_in     = lvl_ff - 1'b1;
         end
      end

      if (done) begin
         lvl_in       = new_level;
         seen_in      = 1'b1;
         nest_in      = NEST_W'(new_level);
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         lvl_ff       <= '0;
         seen_ff      <= 1'b0;
         grows_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         lvl_ff       <= lvl_in;
         seen_ff      <= seen_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            grows_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      addr_ff <= addr_in;
      nest_ff <= nest_in;
      kind_ff <= kind_in;
      ovf_ff  <= ovf_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {(RSP_TDATA_W - NEST_W - KIND_W - 1)'(0), ovf_ff, kind_ff, nest_ff};

   `CTD_ASSERT_SAME(a_tok_onehot0, clock, reset, 1'b1, $onehot0(tok_vec),
      "More than one search token in the cell chain.")
   `CTD_ASSERT_SAME(a_busy_tok, clock, reset, busy_ff, $onehot(tok_vec) && tok_vec[lvl_ff],
      "Search is active but the token is not at the tracked level.")
   `CTD_ASSERT_NEXT(a_walk_start, clock, reset, accept && !done, busy_ff && !rsp_valid_ff,
      "Shallower request did not start a search.")
   `CTD_ASSERT_SAME(a_ovf_top, clock, reset, rsp_valid_ff && ovf_ff,
      lvl_ff == LVL_TOP && kind_ff == KIND_DEEPER,
      "Overflow reported below the top level.")

endmodule

/* rtl/ctd_cell.sv */
// One stack cell: a stored frame address, its compare against the request, and a search token.
module ctd_cell (
   input  logic                   clock,
   input  logic                   reset,
   input  ctd_pkg::addr_type      addr,
   input  ctd_pkg::cell_ctrl_type ctrl,
   input  logic                   sel,
   input  logic                   wr_en,
   input  logic                   tok_from_above,
   input  logic                   below_deeper,
   output ctd_pkg::cell_stat_type stat,
   output logic                   tok
);
   import ctd_pkg::*;

   addr_type entry_ff;
   logic     tok_ff;
   logic     tok_in;

   always_comb begin
      stat.equal  = (addr == entry_ff);
      stat.deeper = ctrl.grows ? (addr > entry_ff) : (addr < entry_ff);
      stat.stop   = tok_ff & below_deeper;
   end

   always_comb begin
      tok_in = tok_ff;
      if (ctrl.load) begin
         tok_in = sel;
      end else if (ctrl.shift) begin
         tok_in = tok_from_above;
      end else if (ctrl.clear) begin
         tok_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff <= 1'b0;
      end else begin
         tok_ff <= tok_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         entry_ff <= addr;
      end
   end

   assign tok = tok_ff;

endmodule

/* bench/call_depth_tracker_test.sv */
// Self-checking testbench for the call depth tracker with stream request and response ports.
`timescale 1ns / 1ps

module call_depth_tracker_test;
   import ctd_pkg::*;

   localparam int STACK_DEPTH = 64;
   localparam int CYCLE_LIMIT = 1500000;
   localparam int SETTLE_CYCLES = STACK_DEPTH + 8;

   typedef struct packed {
      logic [NEST_W-1:0] level;
      logic [KIND_W-1:0] kind;
      logic              overflow;
   } nest_report_type;

   logic                   clock;
   logic                   reset;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata;   // [47:0] frame_address
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   logic [RSP_TDATA_W-1:0] rsp_tdata;   // [5:0] level, [7:6] move_kind,
                                        // [8] overflow, [15:9] zero
   logic                   csr_wr_en;
   logic                   csr_wr_data;

   addr_type        frame_mem [STACK_DEPTH];
   int unsigned     depth_now;
   bit              started;
   bit              upward;
   nest_report_type pending_reports [$];
   addr_type        walk_chain [$];

   bit req_idle_on;
   bit rsp_idle_on;
   int rsp_hold_request;
   int cycle_count;
   int error_count;
   int requests_sent;
   int responses_checked;
   int direction_writes;
   int overflow_seen;
   int kind_seen [4];

   call_depth_tracker #(
      .STACK_DEPTH(STACK_DEPTH)
   ) i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data)
   );

   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   // True when address a lies in a deeper frame than address b.
   function automatic bit is_deeper(input addr_type a, input addr_type b);
      return upward ? (a > b) : (a < b);
   endfunction

   function automatic nest_report_type track_frame(input addr_type a);
      nest_report_type r;
      int unsigned     i;
      r.overflow = 1'b0;
      if (!started) begin
         depth_now = 0;
         r.kind = KIND_FIRST;
      end else if (a == frame_mem[depth_now]) begin
         r.kind = KIND_SAME;
      end else if (is_deeper(a, frame_mem[depth_now])) begin
         r.kind = KIND_DEEPER;
         if (depth_now + 1 < STACK_DEPTH) depth_now++;
         else r.overflow = 1'b1;
      end else begin
         r.kind = KIND_SHALLOW;
         i = depth_now + 1;
         while (i > 0 && !is_deeper(a, frame_mem[i-1])) i--;
         depth_now = i;
      end
      frame_mem[depth_now] = a;
      started = 1'b1;
      r.level = depth_now[NEST_W-1:0];
      return r;
   endfunction

   function automatic addr_type random_addr();
      logic [63:0] w;
      w = {$urandom, $urandom};
      return w[ADDR_W-1:0];
   endfunction

   function automatic int unsigned frame_size();
      return ($urandom_range(0, 9) == 0) ? $urandom_range(1, 1 << 20)
                                         : 16 * $urandom_range(1, 16);
   endfunction

   // Moves an address by step toward deeper or shallower frames and clamps at the ends.
   function automatic addr_type move_frame(input addr_type a, input int unsigned step,
                                           input bit toward_deeper);
      logic [ADDR_W:0] s;
      if (toward_deeper == upward) s = {1'b0, a} + step;
      else s = {1'b0, a} - step;
      if (s[ADDR_W]) return (toward_deeper == upward) ? '1 : '0;
      return s[ADDR_W-1:0];
   endfunction

   function automatic int gap_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 75) return $urandom_range(1, 2);
      if (r < 95) return $urandom_range(3, 8);
      return $urandom_range(20, 60);
   endfunction

   initial begin
      int stall_left;
      rsp_tready = 1'b0;
      stall_left = 0;
      forever begin
         @(negedge clock);
         if (rsp_hold_request > 0) begin
            stall_left = rsp_hold_request;
            rsp_hold_request = 0;
         end else if (stall_left == 0 && rsp_idle_on && $urandom_range(0, 3) == 0) begin
            stall_left = gap_length();
         end
         rsp_tready <= (stall_left == 0);
         if (stall_left > 0) stall_left--;
      end
   end

   always @(posedge clock) begin
      nest_report_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         responses_checked++;
         kind_seen[rsp_tdata[7:6]]++;
         if (rsp_tdata[8]) overflow_seen++;
         if (pending_reports.size() == 0) begin
            error_count++;
            if (error_count <= 10)
               $display("Unexpected response %h at cycle %0d.", rsp_tdata, cycle_count);
         end else begin
            want = pending_reports.pop_front();
            if (rsp_tdata[5:0] !== want.level || rsp_tdata[7:6] !== want.kind ||
                rsp_tdata[8] !== want.overflow || rsp_tdata[15:9] !== '0) begin
               error_count++;
               if (error_count <= 10)
                  $display("Mismatch at cycle %0d: expected level %0d kind %0d overflow %0d,",
                           cycle_count, want.level, want.kind, want.overflow,
                           " got level %0d kind %0d overflow %0d pad %h.",
                           rsp_tdata[5:0], rsp_tdata[7:6], rsp_tdata[8], rsp_tdata[15:9]);
            end
         end
      end
   end

   task automatic send_request(input addr_type a);
      int gap;
      gap = (req_idle_on && $urandom_range(0, 1) == 0) ? gap_length() : 0;
      @(negedge clock);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= a;
      do @(posedge clock); while (!req_tready);
      pending_reports.push_back(track_frame(a));
      requests_sent++;
   endtask

   task automatic wait_for_idle();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending_reports.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_direction(input bit up);
      wait_for_idle();
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= up;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      upward = up;
      direction_writes++;
   endtask

   task automatic test_directed_moves();
      req_idle_on = 1'b0;
      rsp_idle_on = 1'b0;
      send_request(48'hFFFF_FFFF_FFFF);
      send_request(48'hFFFF_FFFF_FFFF);
      send_request(48'h8000_0000_0000);
      send_request(48'h7FFF_FFFF_FFFF);
      send_request(48'h0000_0000_0000);
      send_request(48'h0000_0000_0000);
      send_request(48'h8000_0000_0000);
      // The entry just below is shallower, so the search stops at the current level.
      send_request(48'h9000_0000_0000);
      send_request(48'hFFFF_FFFF_FFFF);
      send_request(48'h5555_5555_5555);
      send_request(48'hAAAA_AAAA_AAAA);
      send_request(48'h0000_0000_0001);
      send_request(48'h0000_0000_0000);
      write_direction(1'b1);
      send_request(48'h0000_0000_0000);
      send_request(48'h0000_0000_0001);
      // With upward growth the search runs all the way down to level zero.
      send_request(48'h0000_0000_0000);
      send_request(48'hFFFF_FFFF_FFFF);
      send_request(48'hFFFF_FFFF_FFFF);
   endtask

   task automatic test_call_walk(input int count, input bit idle);
      addr_type    a;
      int unsigned pick;
      int unsigned j;
      int unsigned n;
      req_idle_on = idle;
      rsp_idle_on = idle;
      repeat (count) begin
         n = walk_chain.size();
         pick = $urandom_range(0, 99);
         if (n == 0 || n > 70 || pick < 6) begin
            a = random_addr();
            walk_chain.delete();
            walk_chain.push_back(a);
         end else if (pick < 12) begin
            a = random_addr();
         end else if (pick < 25) begin
            a = walk_chain[n-1];
         end else if (pick < 68 || n < 2) begin
            a = move_frame(walk_chain[n-1], frame_size(), 1'b1);
            walk_chain.push_back(a);
         end else begin
            j = $urandom_range(0, n - 2);
            case ($urandom_range(0, 2))
               0: a = walk_chain[j];
               1: a = move_frame(walk_chain[j], $urandom_range(1, 15), 1'b1);
               default: a = move_frame(walk_chain[j], $urandom_range(1, 15), 1'b0);
            endcase
            while (walk_chain.size() > j) void'(walk_chain.pop_back());
            walk_chain.push_back(a);
         end
         send_request(a);
      end
   endtask

   task automatic test_stack_overflow(input bit up);
      addr_type    a;
      int unsigned j;
      write_direction(up);
      req_idle_on = 1'b1;
      rsp_idle_on = 1'b1;
      a = up ? addr_type'($urandom_range(0, 1 << 16)) : ~addr_type'($urandom_range(0, 1 << 16));
      walk_chain.delete();
      walk_chain.push_back(a);
      send_request(a);
      repeat (72) begin
         a = move_frame(a, frame_size(), 1'b1);
         walk_chain.push_back(a);
         send_request(a);
      end
      repeat (3) send_request(a);
      j = $urandom_range(4, 12);
      a = walk_chain[j];
      while (walk_chain.size() > j) void'(walk_chain.pop_back());
      walk_chain.push_back(a);
      send_request(a);
      send_request(walk_chain[0]);
   endtask

   task automatic test_backpressure();
      write_direction(1'b0);
      rsp_hold_request = 200;
      test_call_walk(40, 1'b0);
      wait_for_idle();
      test_call_walk(30, 1'b1);
   endtask

   task automatic test_random_calls();
      write_direction(1'b0);
      test_call_walk(300, 1'b1);
      write_direction(1'b1);
      test_call_walk(300, 1'b1);
      write_direction(1'b0);
      test_call_walk(250, 1'b0);
      write_direction(1'b1);
      test_call_walk(250, 1'b1);
   endtask

   initial begin
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      csr_wr_en = 1'b0;
      csr_wr_data = 1'b0;
      req_idle_on = 1'b0;
      rsp_idle_on = 1'b0;
      rsp_hold_request = 0;
      cycle_count = 0;
      error_count = 0;
      requests_sent = 0;
      responses_checked = 0;
      direction_writes = 0;
      overflow_seen = 0;
      kind_seen = '{0, 0, 0, 0};
      depth_now = 0;
      started = 1'b0;
      upward = 1'b0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_directed_moves();
      test_stack_overflow(1'b0);
      test_stack_overflow(1'b1);
      test_backpressure();
      test_random_calls();
      wait_for_idle();

      $display("Sent %0d function-entry requests, checked %0d responses,",
               requests_sent, responses_checked,
               " wrote the direction %0d times.", direction_writes);
      $display("Moves seen: %0d first, %0d same, %0d deeper, %0d shallower, %0d overflows.",
               kind_seen[KIND_FIRST], kind_seen[KIND_SAME], kind_seen[KIND_DEEPER],
               kind_seen[KIND_SHALLOW], overflow_seen);
      if (error_count == 0 && pending_reports.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
